### rtl/core/fqv_pkg.sv
// Shared types and constants for the FASTQ record validator.
// Used by fqv_front, fqv_back and fastq_record_validator; no dependencies.
`default_nettype none

package fqv_pkg;

	// Default width of the internal saturating counters.
	localparam int COUNT_WIDTH = 24;

	// Widths of the result fields on the output stream.
	localparam int OUT_W    = 24;
	localparam int STATUS_W = 3;
	localparam int M_DATA_W = 56; // 3 + 24 + 24 = 51 bits, padded to whole bytes
	localparam int S_DATA_W = 8;

	// Token queue between front and back.
	localparam int QADDR_W = 2;
	localparam int QDEPTH  = 1 << QADDR_W;

	// Byte codes that the classifier looks for.
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_AT   = 8'h40;
	localparam logic [7:0] CH_PLUS = 8'h2B;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_VALID    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_AT    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_PLUS = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd4;
	localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd5;

	// One classified input byte.
	typedef struct packed {
		logic lf;    // line feed: ends the line
		logic term;  // CR or NUL: ends the line's content
		logic at;    // '@'
		logic plus;  // '+'
		logic last;  // last byte of the stream
	} tok_t;

endpackage

`default_nettype wire

### rtl/core/fqv_front.sv
// Front part of the FASTQ record validator: classifies each incoming byte
// and holds the tokens in a short queue. Depends on fqv_pkg.
`default_nettype none

module fqv_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [fqv_pkg::S_DATA_W-1:0]  s_tdata,
	input  wire logic                          s_tlast,
	output logic                               tok_valid,
	output fqv_pkg::tok_t                      tok,
	input  wire logic                          tok_pop
);

	fqv_pkg::tok_t                  tok_in;
	fqv_pkg::tok_t                  queue_q [fqv_pkg::QDEPTH];
	logic [fqv_pkg::QADDR_W-1:0]    wr_ptr_q;
	logic [fqv_pkg::QADDR_W-1:0]    rd_ptr_q;
	logic [fqv_pkg::QADDR_W:0]      count_q;
	logic                           push;
	logic                           pop;

	always_comb begin
		tok_in.lf   = (s_tdata == fqv_pkg::CH_LF);
		tok_in.term = (s_tdata == fqv_pkg::CH_CR) || (s_tdata == fqv_pkg::CH_NUL);
		tok_in.at   = (s_tdata == fqv_pkg::CH_AT);
		tok_in.plus = (s_tdata == fqv_pkg::CH_PLUS);
		tok_in.last = s_tlast;
	end

	assign s_tready  = (count_q != (fqv_pkg::QADDR_W+1)'(fqv_pkg::QDEPTH));
	assign tok_valid = (count_q != '0);
	assign tok       = queue_q[rd_ptr_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = tok_pop && tok_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= tok_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/fqv_back.sv
// Back part of the FASTQ record validator: walks the token stream through
// the record state, judges each record and holds the result in an output
// register. Depends on fqv_pkg.
`default_nettype none

module fqv_back #(
	parameter int COUNT_WIDTH = fqv_pkg::COUNT_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          tok_valid,
	input  wire fqv_pkg::tok_t                 tok,
	output logic                               tok_pop,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [fqv_pkg::M_DATA_W-1:0]       m_tdata
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_SEQ    = 2'd1;
	localparam logic [1:0] PH_PLUS   = 2'd2;
	localparam logic [1:0] PH_QUAL   = 2'd3;

	localparam logic [1:0] PLS_EMPTY = 2'd0;
	localparam logic [1:0] PLS_PLUS  = 2'd1;
	localparam logic [1:0] PLS_OTHER = 2'd2;

	localparam int PAD_W = fqv_pkg::M_DATA_W - fqv_pkg::STATUS_W - 2 * fqv_pkg::OUT_W;

	logic [1:0]                     phase_q, phase_nx;
	logic                           open_q, open_nx;
	logic                           hm_q, hm_nx;
	logic [1:0]                     pls_q, pls_nx;
	logic [COUNT_WIDTH-1:0]         seq_q, seq_nx, seq_upd;
	logic [COUNT_WIDTH-1:0]         qual_q, qual_nx;
	logic [COUNT_WIDTH-1:0]         rec_q, rec_nx;
	logic                           started_q, started_nx;
	logic                           stopped_q, stopped_nx;
	logic                           emit_rec;
	logic                           emit;
	logic [fqv_pkg::STATUS_W-1:0]   st_rec;
	logic [fqv_pkg::STATUS_W-1:0]   st_out;
	logic [fqv_pkg::OUT_W-1:0]      seq_out;
	logic [fqv_pkg::OUT_W-1:0]      rec_out;
	logic                           out_valid_q;
	logic [fqv_pkg::M_DATA_W-1:0]   out_data_q;
	logic                           work;

	assign tok_pop = tok_valid && (!out_valid_q || m_tready);
	assign work    = tok_pop && !stopped_q;

	// Judgement of the record in progress, first failing check wins.
	always_comb begin
		if (!hm_q) begin
			st_rec = fqv_pkg::ST_NO_AT;
		end else if (pls_q != PLS_PLUS) begin
			st_rec = fqv_pkg::ST_BAD_PLUS;
		end else if (seq_q == '0) begin
			st_rec = fqv_pkg::ST_EMPTY;
		end else if (seq_q != qual_q) begin
			st_rec = fqv_pkg::ST_MISMATCH;
		end else begin
			st_rec = fqv_pkg::ST_VALID;
		end
	end

	always_comb begin
		phase_nx   = phase_q;
		open_nx    = open_q;
		hm_nx      = hm_q;
		pls_nx     = pls_q;
		seq_nx     = seq_q;
		qual_nx    = qual_q;
		rec_nx     = rec_q;
		started_nx = started_q;
		stopped_nx = stopped_q;
		emit_rec   = 1'b0;
		emit       = 1'b0;
		if (tok.lf) begin
			if (phase_q == PH_QUAL) begin
				emit_rec = 1'b1;
			end else begin
				phase_nx   = phase_q + 2'd1;
				open_nx    = 1'b1;
				started_nx = 1'b0;
			end
		end else begin
			started_nx = 1'b1;
			if (open_q) begin
				if (tok.term) begin
					open_nx = 1'b0;
				end else begin
					case (phase_q)
						PH_HEADER: begin
							if (!started_q) begin
								hm_nx = tok.at;
							end
						end
						PH_SEQ: begin
							seq_nx = (seq_q == '1) ? seq_q : seq_q + 1'b1;
						end
						PH_PLUS: begin
							pls_nx = (pls_q == PLS_EMPTY && tok.plus) ? PLS_PLUS : PLS_OTHER;
						end
						default: begin
							qual_nx = (qual_q == '1) ? qual_q : qual_q + 1'b1;
						end
					endcase
				end
			end
		end
		seq_upd = seq_nx;
		if (emit_rec) begin
			phase_nx   = PH_HEADER;
			open_nx    = 1'b1;
			hm_nx      = 1'b0;
			pls_nx     = PLS_EMPTY;
			seq_nx     = '0;
			qual_nx    = '0;
			started_nx = 1'b0;
			rec_nx     = (rec_q == '1) ? rec_q : rec_q + 1'b1;
			stopped_nx = (st_rec != fqv_pkg::ST_VALID);
		end
		emit = emit_rec;
		if (tok.last) begin
			if (!emit_rec && (phase_nx != PH_HEADER || started_nx)) begin
				emit = 1'b1;
			end
			stopped_nx = 1'b1;
		end
	end

	assign st_out = emit_rec ? st_rec : fqv_pkg::ST_TRUNC;

	// Cap or widen counts onto the fixed output field width.
	generate
		if (COUNT_WIDTH > fqv_pkg::OUT_W) begin : g_cap
			assign seq_out = (|seq_upd[COUNT_WIDTH-1:fqv_pkg::OUT_W]) ? '1
				: seq_upd[fqv_pkg::OUT_W-1:0];
			assign rec_out = (|rec_q[COUNT_WIDTH-1:fqv_pkg::OUT_W]) ? '1
				: rec_q[fqv_pkg::OUT_W-1:0];
		end else if (COUNT_WIDTH == fqv_pkg::OUT_W) begin : g_same
			assign seq_out = seq_upd;
			assign rec_out = rec_q;
		end else begin : g_ext
			assign seq_out = {{(fqv_pkg::OUT_W-COUNT_WIDTH){1'b0}}, seq_upd};
			assign rec_out = {{(fqv_pkg::OUT_W-COUNT_WIDTH){1'b0}}, rec_q};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			open_q    <= 1'b1;
			hm_q      <= 1'b0;
			pls_q     <= PLS_EMPTY;
			seq_q     <= '0;
			qual_q    <= '0;
			rec_q     <= '0;
			started_q <= 1'b0;
			stopped_q <= 1'b0;
		end else if (work) begin
			phase_q   <= phase_nx;
			open_q    <= open_nx;
			hm_q      <= hm_nx;
			pls_q     <= pls_nx;
			seq_q     <= seq_nx;
			qual_q    <= qual_nx;
			rec_q     <= rec_nx;
			started_q <= started_nx;
			stopped_q <= stopped_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (work && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (work && emit) begin
			out_data_q <= {{PAD_W{1'b0}}, rec_out, seq_out, st_out};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Once stopped, the block stays stopped until reset.
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stopped flag cleared without reset");

	// A token is consumed only when the output register can take a result.
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		tok_pop |-> (!out_valid_q || m_tready))
		else $error("token consumed while result register is blocked");

	// A failing record halts the stream.
	a_bad_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(work && emit_rec && st_rec != fqv_pkg::ST_VALID) |=> stopped_q)
		else $error("bad record did not stop the stream");

	// A finished record restarts at the header line.
	a_rec_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(work && emit_rec) |=> (phase_q == PH_HEADER && !started_q))
		else $error("record state not cleared after a result");

endmodule

`default_nettype wire

### rtl/core/fastq_record_validator.sv
// Top level of the FASTQ record validator: byte classifier with token queue
// (fqv_front) feeding the record checker (fqv_back). Depends on fqv_pkg.
//
//  channel | dir | tdata (low bit up)                               | side
//  --------+-----+--------------------------------------------------+----------------------
//  s_*     | in  | [7:0] data_byte                                  | tlast = end_of_input
//  m_*     | out | [2:0] status, [26:3] sequence_length,            | none
//          |     | [50:27] record_number, [55:51] zero              |
//
//  One byte is taken every cycle while the four-entry token queue has room.
//  A result reaches m_tvalid by way of the token queue and the output register:
//  the token of the byte that causes it is written into the queue, then read
//  from the queue and loaded into the output register.
//  The back part retires one token per cycle; it holds only while a result
//  waits in the output register and m_tready is low, and the queue absorbs
//  up to four bytes meanwhile before s_tready drops.
//  arst_n clears the queue, the record state, the record count and the
//  stopped flag; after a bad record or the last byte all input is dropped.
`default_nettype none

module fastq_record_validator #(
	parameter int COUNT_WIDTH = fqv_pkg::COUNT_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input byte stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [fqv_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] data_byte
	input  wire logic                          s_tlast,   // end_of_input
	// result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [fqv_pkg::M_DATA_W-1:0]       m_tdata    // status, sequence_length,
	                                                      // record_number, zero pad
);

	logic          tok_valid;
	fqv_pkg::tok_t tok;
	logic          tok_pop;

	// Classify each transfer and queue it.
	fqv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_pop   (tok_pop)
	);

	// Advance record state and drive results.
	fqv_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_pop   (tok_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire
